// File: sv/tmcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcm_pkg
// Shared constants, codes and types of the tile map collision mover.
// ----------------------------------------------------------------------------
package tmcm_pkg;

    // tile grid size, one memory row per tile row
    localparam int MAP_COLS = 20;
    localparam int MAP_ROWS = 15;

    localparam int RA_W = $clog2(MAP_ROWS);
    localparam int CA_W = $clog2(MAP_COLS);

    localparam logic [7:0] COL_LIM = 8'(MAP_COLS);
    localparam logic [7:0] ROW_LIM = 8'(MAP_ROWS);

    localparam logic [15:0] LIMIT_X = 16'd608;
    localparam logic [15:0] LIMIT_Y = 16'd416;
    localparam logic [15:0] HALF_H  = 16'd32;

    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 1;

    typedef logic [7:0] t_num;

    typedef enum logic [1:0] {
        OP_PLACE = 2'd0,
        OP_STEP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_RD,
        S_EV,
        S_WRD,
        S_WWB,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                rd_en;
        logic [RA_W-1:0]     rd_addr;
        logic                wr_en;
        logic [RA_W-1:0]     wr_addr;
        logic [MAP_COLS-1:0] wr_data;
    } t_ram_req;

endpackage

// File: sv/tmcm_row_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcm_row_ram
// Solid-tile memory, one word per tile row, registered read with row valid
// bits so that rows never written read as all passable.
// ----------------------------------------------------------------------------
module tmcm_row_ram
    import tmcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ram_req            i_req,
    output logic [MAP_COLS-1:0] o_rd_data
);

    logic [MAP_COLS-1:0] r_mem [MAP_ROWS];
    logic [MAP_ROWS-1:0] r_valid;
    logic [MAP_COLS-1:0] r_rd_data;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: sv/tmcm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcm_ctrl
// Sequencer: position registers, bound check, row-by-row tile scan and
// read-modify-write of tile rows, plus the output register.
// ----------------------------------------------------------------------------
module tmcm_ctrl
    import tmcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    input  logic [S_USER_W-1:0] i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    output logic [M_USER_W-1:0] o_m_axis_tuser,
    output t_ram_req            o_ram_req,
    input  logic [MAP_COLS-1:0] i_rd_data
);

    t_state r_state, n_state;

    logic [15:0]         r_x, r_y;
    logic [15:0]         r_tx, r_ty;
    t_num                r_row, r_wrow, r_wcol;
    logic [1:0]          r_rows_left;
    logic                r_solid, r_blk;
    logic                r_m_valid;
    logic [15:0]         r_out_x, r_out_y, r_out_ly;
    logic                r_out_blk;

    t_op                 w_op;
    logic [15:0]         w_abs_x, w_abs_y;
    logic signed [15:0]  w_dx, w_dy;
    logic [4:0]          w_col;
    logic [3:0]          w_row;
    logic                w_solid;
    logic                w_acc, w_load, w_wr_ok, w_oob;
    t_num                w_c0, w_c1;
    logic                w_two_cols, w_row_in, w_hit;
    logic [MAP_COLS-1:0] w_patched;

    assign w_op    = t_op'(i_s_axis_tuser);
    assign w_abs_x = i_s_axis_tdata[15:0];
    assign w_abs_y = i_s_axis_tdata[31:16];
    assign w_dx    = i_s_axis_tdata[47:32];
    assign w_dy    = i_s_axis_tdata[63:48];
    assign w_col   = i_s_axis_tdata[68:64];
    assign w_row   = i_s_axis_tdata[72:69];
    assign w_solid = i_s_axis_tdata[73];

    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_wr_ok = ({3'b000, w_col} < COL_LIM) && ({4'b0000, w_row} < ROW_LIM);
    assign w_oob   = (r_tx > LIMIT_X) || (r_ty > LIMIT_Y);

    // covered tiles of the current row; tiles beyond the grid are passable
    assign w_c0       = r_tx[12:5];
    assign w_c1       = w_c0 + 8'd1;
    assign w_two_cols = (r_tx[4:0] != 5'd0);
    assign w_row_in   = (r_row < ROW_LIM);
    assign w_hit      = w_row_in &&
                        (((w_c0 < COL_LIM) && i_rd_data[w_c0[CA_W-1:0]]) ||
                         (w_two_cols && (w_c1 < COL_LIM) && i_rd_data[w_c1[CA_W-1:0]]));

    always_comb begin
        w_patched = i_rd_data;
        w_patched[r_wcol[CA_W-1:0]] = r_solid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (w_op) inside
                        OP_PLACE, OP_NOP: n_state = S_DONE;
                        OP_STEP:          n_state = S_BOUND;
                        OP_WRITE:         n_state = w_wr_ok ? S_WRD : S_DONE;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_BOUND: n_state = w_oob ? S_DONE : S_RD;
            S_RD:    n_state = S_EV;
            S_EV:    n_state = (w_hit || (r_rows_left == 2'd0)) ? S_DONE : S_RD;
            S_WRD:   n_state = S_WWB;
            S_WWB:   n_state = S_DONE;
            S_DONE:  n_state = (!r_m_valid || i_m_axis_tready) ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready   = 1'b0;
        w_load            = 1'b0;
        o_ram_req.rd_en   = 1'b0;
        o_ram_req.rd_addr = r_row[RA_W-1:0];
        o_ram_req.wr_en   = 1'b0;
        o_ram_req.wr_addr = r_wrow[RA_W-1:0];
        o_ram_req.wr_data = w_patched;
        unique case (r_state)
            S_IDLE:  o_s_axis_tready = 1'b1;
            S_RD:    o_ram_req.rd_en = w_row_in;
            S_WRD: begin
                o_ram_req.rd_en   = 1'b1;
                o_ram_req.rd_addr = r_wrow[RA_W-1:0];
            end
            S_WWB:   o_ram_req.wr_en = 1'b1;
            S_DONE:  w_load = !r_m_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_x       <= '0;
            r_y       <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_acc && (w_op == OP_PLACE)) begin
                r_x <= w_abs_x;
                r_y <= w_abs_y;
            end
            // last covered row passed: take the move
            if ((r_state == S_EV) && !w_hit && (r_rows_left == 2'd0)) begin
                r_x <= r_tx;
                r_y <= r_ty;
            end
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_tx    <= r_x + $unsigned(w_dx);
                    r_ty    <= r_y + $unsigned(w_dy);
                    r_wcol  <= {3'b000, w_col};
                    r_wrow  <= {4'b0000, w_row};
                    r_solid <= w_solid;
                    r_blk   <= 1'b0;
                end
            end
            S_BOUND: begin
                r_row       <= r_ty[12:5];
                r_rows_left <= (r_ty[4:0] == 5'd0) ? 2'd1 : 2'd2;
                if (w_oob) begin
                    r_blk <= 1'b1;
                end
            end
            S_EV: begin
                if (w_hit) begin
                    r_blk <= 1'b1;
                end else begin
                    r_row       <= r_row + 8'd1;
                    r_rows_left <= r_rows_left - 2'd1;
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_out_x   <= r_x;
            r_out_y   <= r_y;
            r_out_ly  <= r_y + HALF_H;
            r_out_blk <= r_blk;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_out_ly, r_out_y, r_out_x};
    assign o_m_axis_tuser  = r_out_blk;

endmodule

// File: sv/tile_map_collision_mover_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_map_collision_mover_core
// Entity mover on a solid-tile grid with collision refusal.
// ----------------------------------------------------------------------------
// Usage:
//   slave stream takes one command beat: tuser is the opcode (place, step,
//   tile write, no-op), tdata carries the position, deltas and tile fields.
//   master stream returns exactly one beat per command: tdata holds pos_x,
//   pos_y and lower_y, tuser holds the blocked flag.
//   one command at a time: place and no-op go straight to the result
//   register, a tile write reads the row and then writes it back, or goes
//   straight to the result when it falls off the grid, and a step checks the
//   bounds and, when in bounds, reads and evaluates each scanned tile row in
//   turn (2 or 3 rows, the scan stops at the first solid row).
//   tready drops after each accepted beat and returns when the result has
//   entered the output register, which holds it while the receiver stalls;
//   a stall longer than the next command blocks only at that result.
//   reset clears the position to 0,0 and all row valid bits, so every tile
//   reads as passable without a clearing pass; the block is ready at once.
// ----------------------------------------------------------------------------
module tile_map_collision_mover_core
    import tmcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // abs_x, abs_y, delta_x, delta_y, tile_col, tile_row, tile_solid, zero pad
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // opcode
    input  logic [S_USER_W-1:0] i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // pos_x, pos_y, lower_y
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // blocked
    output logic [M_USER_W-1:0] o_m_axis_tuser
);

    t_ram_req            w_ram_req;
    logic [MAP_COLS-1:0] w_rd_data;

    tmcm_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_ram_req       (w_ram_req),
        .i_rd_data       (w_rd_data)
    );

    tmcm_row_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_ram_req),
        .o_rd_data (w_rd_data)
    );

endmodule

// File: sv/tmcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcm_checker
// Port-level checks of the tile map collision mover.
// ----------------------------------------------------------------------------
module tmcm_checker
    import tmcm_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_axis_tvalid,
    input logic                o_s_axis_tready,
    input logic [S_DATA_W-1:0] i_s_axis_tdata,
    input logic [S_USER_W-1:0] i_s_axis_tuser,
    input logic                o_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] o_m_axis_tdata,
    input logic [M_USER_W-1:0] o_m_axis_tuser
);

    // result register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat present after reset");

    // one command in flight: busy the cycle after an accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("second command accepted back to back");

    // lower half sits 32 pixels below the upper half
    a_lower_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[47:32] == 16'(o_m_axis_tdata[31:16] + HALF_H)))
        else $error("lower_y does not match pos_y");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result beat changed while stalled");

endmodule

bind tile_map_collision_mover_core tmcm_checker u_tmcm_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tile map collision mover core.
// Drives place, step, tile write and no-op commands over the slave stream.
// A scoreboard class tracks the entity position and the solid-tile grid and
// checks every returned beat in order. Idling phases and one long receiver
// hold put gaps and back-pressure on every phase of the block's work.
// ----------------------------------------------------------------------------
module tb_top;
    import tmcm_pkg::*;

    localparam int TILE_PIX       = 32;
    localparam int N_RANDOM       = 620;
    localparam int N_PRESSURE     = 12;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 24;

    typedef struct {
        logic [15:0] abs_x;
        logic [15:0] abs_y;
        logic [15:0] delta_x;
        logic [15:0] delta_y;
        logic [4:0]  tile_col;
        logic [3:0]  tile_row;
        logic        tile_solid;
    } t_cmd;

    typedef struct {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] lower_y;
        logic        blocked;
    } t_pos_beat;

    class position_scoreboard;
        logic [15:0] ent_x;
        logic [15:0] ent_y;
        bit          tile_map [MAP_ROWS][MAP_COLS];
        t_pos_beat   expected_pos_q [$];
        int          errors;
        int          n_cmds;
        int          n_steps;
        int          n_refused;
        int          n_checked;

        function new();
            ent_x = '0;
            ent_y = '0;
            foreach (tile_map[r, c]) tile_map[r][c] = 1'b0;
            errors    = 0;
            n_cmds    = 0;
            n_steps   = 0;
            n_refused = 0;
            n_checked = 0;
        endfunction

        // tiles outside the grid read as passable
        function bit tile_is_solid(int col, int row);
            if (col >= MAP_COLS || row >= MAP_ROWS) return 1'b0;
            return tile_map[row][col];
        endfunction

        function bit move_refused(logic [15:0] tx, logic [15:0] ty);
            int c0, r0, ncols, nrows;
            if (tx > LIMIT_X || ty > LIMIT_Y) return 1'b1;
            c0    = int'(tx) / TILE_PIX;
            r0    = int'(ty) / TILE_PIX;
            ncols = (int'(tx) % TILE_PIX == 0) ? 1 : 2;
            nrows = (int'(ty) % TILE_PIX == 0) ? 2 : 3;
            for (int r = 0; r < nrows; r++)
                for (int c = 0; c < ncols; c++)
                    if (tile_is_solid(c0 + c, r0 + r)) return 1'b1;
            return 1'b0;
        endfunction

        function void note_command(t_op op, t_cmd c);
            t_pos_beat   e;
            logic [15:0] tx, ty;
            e.blocked = 1'b0;
            case (op)
                OP_PLACE: begin
                    ent_x = c.abs_x;
                    ent_y = c.abs_y;
                end
                OP_STEP: begin
                    n_steps++;
                    tx = ent_x + c.delta_x;
                    ty = ent_y + c.delta_y;
                    if (move_refused(tx, ty)) begin
                        e.blocked = 1'b1;
                        n_refused++;
                    end else begin
                        ent_x = tx;
                        ent_y = ty;
                    end
                end
                OP_WRITE: begin
                    if (c.tile_col < MAP_COLS && c.tile_row < MAP_ROWS)
                        tile_map[c.tile_row][c.tile_col] = c.tile_solid;
                end
                default: ;
            endcase
            e.pos_x   = ent_x;
            e.pos_y   = ent_y;
            e.lower_y = ent_y + HALF_H;
            expected_pos_q.push_back(e);
            n_cmds++;
        endfunction

        function void check_beat(logic [M_DATA_W-1:0] data, logic blocked);
            t_pos_beat e;
            if (expected_pos_q.size() == 0) begin
                $display("%0t unexpected beat: pos_x %0d pos_y %0d lower_y %0d blocked %0b",
                         $time, data[15:0], data[31:16], data[47:32], blocked);
                errors++;
                return;
            end
            e = expected_pos_q.pop_front();
            n_checked++;
            if (data[15:0] !== e.pos_x) begin
                $display("%0t pos_x mismatch: expected %0d, actual %0d",
                         $time, e.pos_x, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.pos_y) begin
                $display("%0t pos_y mismatch: expected %0d, actual %0d",
                         $time, e.pos_y, data[31:16]);
                errors++;
            end
            if (data[47:32] !== e.lower_y) begin
                $display("%0t lower_y mismatch: expected %0d, actual %0d",
                         $time, e.lower_y, data[47:32]);
                errors++;
            end
            if (blocked !== e.blocked) begin
                $display("%0t blocked mismatch: expected %0b, actual %0b",
                         $time, e.blocked, blocked);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pos_q.size();
        endfunction
    endclass

    logic                i_clk;
    logic                rst_n         = 1'b0;
    logic                s_tvalid      = 1'b0;
    logic [S_DATA_W-1:0] s_tdata       = '0;
    logic [S_USER_W-1:0] s_tuser       = '0;
    logic                m_tready      = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic [M_USER_W-1:0] o_m_axis_tuser;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    bit long_hold_req  = 1'b0;

    position_scoreboard sb;

    tile_map_collision_mover_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one beat: idle gap first, then hold tvalid until tready
    task automatic send_cmd(t_op op, t_cmd c);
        int gap;
        gap = 0;
        while (gap < 100 && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, c.tile_solid, c.tile_row, c.tile_col,
                     c.delta_y, c.delta_x, c.abs_y, c.abs_x};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_command(op, c);
    endtask

    task automatic send_fields(t_op op, int ax, int ay, int dx, int dy,
                               int col, int row, bit solid);
        t_cmd c;
        c.abs_x      = 16'(ax);
        c.abs_y      = 16'(ay);
        c.delta_x    = 16'(dx);
        c.delta_y    = 16'(dy);
        c.tile_col   = 5'(col);
        c.tile_row   = 4'(row);
        c.tile_solid = solid;
        send_cmd(op, c);
    endtask

    // mostly tile-sized or pixel-sized moves so the entity walks into tiles
    function automatic logic [15:0] walk_delta();
        case ($urandom_range(0, 3))
            0:       return 16'(($urandom_range(0, 4) - 2) * TILE_PIX);
            1:       return 16'($urandom_range(0, 80) - 40);
            2:       return 16'h0000;
            default: return 16'($urandom_range(0, 16) - 8);
        endcase
    endfunction

    task automatic send_random_cmd();
        t_cmd c;
        t_op  op;
        int   pick;
        c.abs_x      = 16'($urandom);
        c.abs_y      = 16'($urandom);
        c.delta_x    = 16'($urandom);
        c.delta_y    = 16'($urandom);
        c.tile_col   = 5'($urandom);
        c.tile_row   = 4'($urandom);
        c.tile_solid = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            op        = OP_STEP;
            c.delta_x = walk_delta();
            c.delta_y = walk_delta();
        end else if (pick < 60) begin
            op      = OP_PLACE;
            c.abs_x = 16'($urandom_range(0, 640));
            c.abs_y = 16'($urandom_range(0, 448));
            if ($urandom_range(0, 1)) c.abs_x[4:0] = '0;
            if ($urandom_range(0, 1)) c.abs_y[4:0] = '0;
        end else if (pick < 80) begin
            op           = OP_WRITE;
            c.tile_col   = 5'($urandom_range(0, MAP_COLS - 1));
            c.tile_row   = 4'($urandom_range(0, MAP_ROWS - 1));
            c.tile_solid = ($urandom_range(0, 99) < 35);
        end else begin
            // any opcode with raw fields: wild deltas, far places, off-grid writes
            op = t_op'($urandom_range(0, 3));
        end
        send_cmd(op, c);
    endtask

    initial begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && m_tready)
                sb.check_beat(o_m_axis_tdata, o_m_axis_tuser[0]);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no beat for %0d cycles", $time, quiet);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int src_pct  [4] = '{0, 81, 0, 38};
        int sink_pct [4] = '{0, 0, 81, 38};
        sb = new();
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // bounds, wrap of negative targets and the position extremes
        send_fields(OP_NOP,   0, 0, 0, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 0, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, -1, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 0, -1, 0, 0, 0);
        send_fields(OP_PLACE, 608, 416, 0, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 0, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 1, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 0, 1, 0, 0, 0);
        send_fields(OP_PLACE, 65535, 65535, 0, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 0, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, -32768, 32767, 0, 0, 0);
        // corner tile, unaligned target covering two columns and three rows
        send_fields(OP_WRITE, 0, 0, 0, 0, 19, 14, 1);
        send_fields(OP_PLACE, 590, 400, 0, 0, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 0, 0, 0, 0, 0);
        // writes off the grid are dropped
        send_fields(OP_WRITE, 0, 0, 0, 0, 31, 15, 1);
        send_fields(OP_WRITE, 0, 0, 0, 0, 20, 0, 1);
        send_fields(OP_WRITE, 0, 0, 0, 0, 0, 15, 1);
        send_fields(OP_WRITE, 0, 0, 0, 0, 19, 14, 0);
        send_fields(OP_STEP,  0, 0, 0, 0, 0, 0, 0);
        // aligned x covers one column only
        send_fields(OP_PLACE, 0, 0, 0, 0, 0, 0, 0);
        send_fields(OP_WRITE, 0, 0, 0, 0, 1, 2, 1);
        send_fields(OP_STEP,  0, 0, 1, 64, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 0, 64, 0, 0, 0);
        send_fields(OP_STEP,  0, 0, 32767, 0, 0, 0, 0);

        // receiver holds off while commands keep coming
        long_hold_req <= 1'b1;
        repeat (N_PRESSURE) send_random_cmd();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   <= src_pct[ph];
            sink_stall_pct <= sink_pct[ph];
            repeat (N_RANDOM / 4) send_random_cmd();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d commands, %0d steps of which %0d refused, %0d beats checked",
                 sb.n_cmds, sb.n_steps, sb.n_refused, sb.n_checked);
        $display("idling phases: none, sender, receiver, both; plus one long receiver hold");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
